// ===== src/clns_pkg.sv =====
// ----------------------------------------------------------------------------
// clns_pkg: shared types and constants of the character display sequencer
// Holds the request kinds, register indexes, the state type and the fixed
// command bytes of the power-up run.
// ----------------------------------------------------------------------------
package clns_pkg;

  // Request kinds carried in the mode field
  localparam logic [1:0] MODE_CMD    = 2'd0;
  localparam logic [1:0] MODE_DATA   = 2'd1;
  localparam logic [1:0] MODE_INIT   = 2'd2;
  localparam logic [1:0] MODE_CURSOR = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_PULSE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_CMD     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POWER_UP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_INIT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_STEP    = 3'd5;

  // Display command bytes and nibbles
  localparam logic [3:0] NIB_WAKE      = 4'h3;
  localparam logic [3:0] NIB_4BIT      = 4'h2;
  localparam logic [7:0] CMD_FUNC_SET  = 8'h28;
  localparam logic [7:0] CMD_DISP_ON   = 8'h0C;
  localparam logic [7:0] CMD_ENTRY     = 8'h06;
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_HOME      = 8'h02;
  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
  localparam logic [7:0] ROW1_OFFSET   = 8'h40;

  // Step counter: the power-up run is the longest, twelve strobes
  localparam int unsigned STEP_W      = 4;
  localparam logic [STEP_W-1:0] LAST_STEP_INIT = 4'd11;
  localparam logic [STEP_W-1:0] LAST_STEP_BYTE = 4'd1;
  localparam logic [STEP_W-1:0] INIT_BYTE_STEP = 4'd4;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } state_t;

  // Command byte sent at a given byte slot of the power-up run
  function automatic logic [7:0] init_cmd(input logic [2:0] slot);
    logic [7:0] b;
    case (slot)
      3'd2:    b = CMD_FUNC_SET;
      3'd3:    b = CMD_DISP_ON;
      3'd4:    b = CMD_ENTRY;
      3'd5:    b = CMD_CLEAR;
      default: b = CMD_CLEAR;
    endcase
    return b;
  endfunction

endpackage

// ===== src/char_lcd_nibble_sequencer.sv =====
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer: 4-bit character display interface controller
// Expands one display request into its run of nibble strobes with waits.
// ----------------------------------------------------------------------------
// A request taken on the slave stream produces one nibble strobe per cycle on
// the master stream while the master side does not stall: two strobes for a
// command byte, a data byte or a cursor move, twelve for the power-up run. The
// step counter walks the strobes of one request and a single wait adder forms
// the wait after each strobe. s_tready is low while a request is being
// expanded. The enable width register is accepted and not stored: the
// downstream pin driver times it.
module char_lcd_nibble_sequencer #(
  parameter int unsigned NUM_DISPLAYS = 2
) (
  input  logic                              clk,
  input  logic                              rst,
  // Request stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [23:0]                       s_tdata,   // byte_value[7:0], column[13:8],
                                                       // row[21:14], zero[23:22]
  input  logic [2:0]                        s_tuser,   // mode[1:0], lcd_target[2]
  // Strobe stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [39:0]                       m_tdata,   // nibble[3:0], wait_before_us[19:4],
                                                       // wait_after_us[36:20], zero[39:37]
  output logic [1:0]                        m_tuser,   // enable_select[0], reg_select[1]
  output logic                              m_tlast,
  // Configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [clns_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [15:0]                       cfg_data
);
  import clns_pkg::*;

  localparam int unsigned MaxSel    = NUM_DISPLAYS - 1;
  localparam logic        MaxSelBit = MaxSel[0];

  // Timing registers
  logic [15:0] settle_us;
  logic [15:0] long_command_us;
  logic [15:0] power_up_us;
  logic [15:0] first_init_us;
  logic [15:0] init_step_us;

  // Request registers
  state_t             state, state_next;
  logic [1:0]         mode_r;
  logic               sel_r;
  logic [7:0]         byte_r;
  logic [STEP_W-1:0]  step, step_next;
  logic [STEP_W-1:0]  last_step;

  // Output register
  logic               out_valid, out_valid_next;
  logic [3:0]         out_nibble;
  logic [15:0]        out_before;
  logic [16:0]        out_after;
  logic               out_rs;
  logic               out_sel;
  logic               out_last;

  // Request decode
  logic [1:0]  in_mode;
  logic        in_target;
  logic        in_sel;
  logic [7:0]  in_byte;
  logic [5:0]  in_column;
  logic [7:0]  in_row;
  logic [7:0]  cursor_addr;
  logic        accept;
  logic        advance;

  // Current strobe
  logic        is_init;
  logic        is_hi;
  logic        cur_rs;
  logic [7:0]  cur_byte;
  logic [3:0]  cur_nibble;
  logic [15:0] cur_before;
  logic [15:0] cur_extra;
  logic [16:0] cur_after;
  logic        cur_last;

  assign in_mode   = s_tuser[1:0];
  assign in_target = s_tuser[2];
  assign in_byte   = s_tdata[7:0];
  assign in_column = s_tdata[13:8];
  assign in_row    = s_tdata[21:14];

  // Clamp the target to the last display
  assign in_sel = (32'(in_target) > MaxSel) ? MaxSelBit : in_target;

  // Row one and above share the second line offset
  assign cursor_addr = CMD_SET_DDRAM
                     | (((in_row != 8'd0) ? ROW1_OFFSET : 8'd0) + {2'b00, in_column});

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign advance   = (state == ST_RUN) && (!out_valid || m_tready);
  assign cfg_ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      settle_us       <= 16'd40;
      long_command_us <= 16'd2000;
      power_up_us     <= 16'd40000;
      first_init_us   <= 16'd5000;
      init_step_us    <= 16'd150;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SETTLE:     settle_us       <= cfg_data;
        CFG_LONG_CMD:   long_command_us <= cfg_data;
        CFG_POWER_UP:   power_up_us     <= cfg_data;
        CFG_FIRST_INIT: first_init_us   <= cfg_data;
        CFG_INIT_STEP:  init_step_us    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Decode the strobe at the current step
  always_comb begin
    is_init  = (mode_r == MODE_INIT);
    is_hi    = ~step[0];
    cur_rs   = (mode_r == MODE_DATA);
    cur_byte = is_init ? init_cmd(step[3:1]) : byte_r;
    cur_last = (step == last_step);
    if (is_init && step < INIT_BYTE_STEP) begin
      cur_nibble = (step == 4'd3) ? NIB_4BIT : NIB_WAKE;
    end else begin
      cur_nibble = is_hi ? cur_byte[7:4] : cur_byte[3:0];
    end
    cur_before = (is_init && step == '0) ? power_up_us : 16'd0;
    if (is_init && step == '0) begin
      cur_extra = first_init_us;
    end else if (is_init && step < INIT_BYTE_STEP) begin
      cur_extra = init_step_us;
    end else if (!is_hi && !cur_rs && (cur_byte == CMD_CLEAR || cur_byte == CMD_HOME)) begin
      cur_extra = long_command_us;
    end else begin
      cur_extra = 16'd0;
    end
    // Shared wait adder
    cur_after = {1'b0, settle_us} + {1'b0, cur_extra};
  end

  // Next state and handshake control
  always_comb begin
    state_next     = state;
    step_next      = step;
    out_valid_next = out_valid;
    if (m_tready) begin
      out_valid_next = 1'b0;
    end
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_RUN;
          step_next  = '0;
        end
      end
      ST_RUN: begin
        if (advance) begin
          out_valid_next = 1'b1;
          step_next      = step + 1'b1;
          if (cur_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

  // Latch the request
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r    <= in_mode;
      sel_r     <= in_sel;
      byte_r    <= (in_mode == MODE_CURSOR) ? cursor_addr : in_byte;
      last_step <= (in_mode == MODE_INIT) ? LAST_STEP_INIT : LAST_STEP_BYTE;
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (advance) begin
      out_nibble <= cur_nibble;
      out_before <= cur_before;
      out_after  <= cur_after;
      out_rs     <= cur_rs;
      out_sel    <= sel_r;
      out_last   <= cur_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_after, out_before, out_nibble};
  assign m_tuser  = {out_rs, out_sel};
  assign m_tlast  = out_last;

endmodule

// ===== src/clns_checker.sv =====
// ----------------------------------------------------------------------------
// clns_checker: port-level checks of the character display sequencer
// Watches the request and strobe streams and reports protocol slips.
// ----------------------------------------------------------------------------
module clns_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  // Hold a stalled strobe
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled strobe changed");

  // Drop ready once a request is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while busy");

  // Only a command strobe carries a wait before it
  a_before_cmd_only: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[19:4] != 16'd0) |-> !m_tuser[1])
    else $error("wait before on a data strobe");

  // Start with an empty output after reset
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_tvalid)
    else $error("strobe valid right after reset");

endmodule

bind char_lcd_nibble_sequencer clns_checker u_clns_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
